>>> rtl/e2c_pkg.sv
`timescale 1ns / 1ps

package e2c_pkg;

  localparam int EPOCH_W = 40;
  localparam int OFS_W   = 17;
  localparam int BIAS_W  = 40;
  localparam int YEAR_W  = 16;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int NEXT_W  = 41;

  // biased day number and second of day between the split and the later stages
  localparam int DNUM_W  = 24;
  localparam int SOD_W   = 17;

  localparam int NSTG    = 11;

  // Eras added so that the biased day number is never negative and already
  // carries the 1970-01-01 to 0000-03-01 shift.
  localparam int               ERA_BIAS   = 39;
  localparam longint unsigned  DAY_BIAS   = 64'd719468 + 64'(ERA_BIAS) * 64'd146097;
  localparam longint unsigned  SEC_BIAS   = DAY_BIAS * 64'd86400;
  localparam longint           OFS_RESET  = 28800;
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(SEC_BIAS + 64'(OFS_RESET));

  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctl_t;

  // first day of year (March based) for each shifted month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ds;
    case (mp)
      4'd0:    ds = 9'd0;
      4'd1:    ds = 9'd31;
      4'd2:    ds = 9'd61;
      4'd3:    ds = 9'd92;
      4'd4:    ds = 9'd122;
      4'd5:    ds = 9'd153;
      4'd6:    ds = 9'd184;
      4'd7:    ds = 9'd214;
      4'd8:    ds = 9'd245;
      4'd9:    ds = 9'd275;
      4'd10:   ds = 9'd306;
      4'd11:   ds = 9'd337;
      default: ds = 9'd0;
    endcase
    return ds;
  endfunction

endpackage

>>> rtl/e2c_in_if.sv
`timescale 1ns / 1ps

interface e2c_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2c_pkg::EPOCH_W-1:0]  epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

>>> rtl/e2c_out_if.sv
`timescale 1ns / 1ps

interface e2c_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [e2c_pkg::YEAR_W-1:0]   civil_year;
  logic        [e2c_pkg::MONTH_W-1:0]  civil_month;
  logic        [e2c_pkg::DAY_W-1:0]    civil_day;
  logic        [e2c_pkg::HOUR_W-1:0]   local_hour;
  logic        [e2c_pkg::MIN_W-1:0]    local_minute;
  logic signed [e2c_pkg::NEXT_W-1:0]   next_midnight_epoch;

  modport source (output valid, output civil_year, output civil_month, output civil_day,
                  output local_hour, output local_minute, output next_midnight_epoch,
                  input ready);
  modport sink   (input valid, input civil_year, input civil_month, input civil_day,
                  input local_hour, input local_minute, input next_midnight_epoch,
                  output ready);
endinterface

>>> rtl/e2c_pipe_ctrl.sv
`timescale 1ns / 1ps

module e2c_pipe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output e2c_pkg::pipe_ctl_t  ctl
);

  localparam int N = e2c_pkg::NSTG;

  logic [N-1:0] v_r;
  logic [N-1:0] v_nxt;
  logic [N:0]   rdy;

  // a stage takes new contents when empty or when the one after it moves
  always_comb begin
    rdy[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < N; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rst_n && rdy[0];
  assign out_valid = v_r[N-1];
  assign ctl.en    = rdy[N-1:0];

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
      (in_valid && in_ready) |=> v_r[0])
    else $error("accepted request did not enter the first stage");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) |-> ($countones(v_r) == $countones($past(v_r))
                        + int'($past(in_valid && in_ready))
                        - int'($past(v_r[N-1] && out_ready))))
    else $error("request lost or duplicated in the pipeline");

endmodule

>>> rtl/e2c_day_split.sv
`timescale 1ns / 1ps

module e2c_day_split (
  input  logic                                clk,
  input  e2c_pkg::pipe_ctl_t                  ctl,
  input  logic signed [e2c_pkg::EPOCH_W-1:0]  epoch,
  input  logic [e2c_pkg::BIAS_W-1:0]          bias,
  output logic [e2c_pkg::DNUM_W-1:0]          dnum,
  output logic [e2c_pkg::SOD_W-1:0]           sod
);

  localparam int U_W    = e2c_pkg::BIAS_W + 1;
  localparam int X_W    = 24;
  localparam int RCP_S  = X_W + 10;
  localparam int RCP_W  = 25;
  localparam int PROD_W = X_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_675 =
      RCP_W'(((64'd1 << RCP_S) + 64'd674) / 64'd675);

  logic [U_W-1:0]    u_nxt, u_r;
  logic [16:0]       qh, ql;
  logic [X_W-1:0]    x_nxt, x_r, x2_r;
  logic [24:0]       base_nxt, base_r, base2_r;
  logic [6:0]        r7_r, r7b_r;
  logic [PROD_W-1:0] prod;
  logic [14:0]       qd_nxt, qd_r;
  logic [e2c_pkg::DNUM_W-1:0] dnum_nxt, dnum_r;
  logic [9:0]        rem;
  logic [e2c_pkg::SOD_W-1:0]  sod_nxt, sod_r;

  // biased local seconds, never negative
  assign u_nxt = {epoch[e2c_pkg::EPOCH_W-1], epoch} + {1'b0, bias};

  // 86400 = 128 * 675; split the /675 as 2^17 = 194 * 675 + 122
  assign qh       = u_r[U_W-1:24];
  assign ql       = u_r[23:7];
  assign x_nxt    = X_W'({7'd0, qh} * 24'd122) + {7'd0, ql};
  assign base_nxt = {8'd0, qh} * 25'd194;

  assign prod   = PROD_W'(x_r) * PROD_W'(RCP_675);
  assign qd_nxt = prod[PROD_W-1:RCP_S];

  assign dnum_nxt = e2c_pkg::DNUM_W'(base2_r + 25'(qd_r));
  assign rem      = 10'(x2_r - X_W'(qd_r) * 24'd675);
  assign sod_nxt  = {rem, r7b_r};

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      u_r <= u_nxt;
    end
    if (ctl.en[1]) begin
      x_r    <= x_nxt;
      base_r <= base_nxt;
      r7_r   <= u_r[6:0];
    end
    if (ctl.en[2]) begin
      qd_r    <= qd_nxt;
      x2_r    <= x_r;
      base2_r <= base_r;
      r7b_r   <= r7_r;
    end
    if (ctl.en[3]) begin
      dnum_r <= dnum_nxt;
      sod_r  <= sod_nxt;
    end
  end

  assign dnum = dnum_r;
  assign sod  = sod_r;

endmodule

>>> rtl/e2c_civil_date.sv
`timescale 1ns / 1ps

module e2c_civil_date (
  input  logic                                clk,
  input  e2c_pkg::pipe_ctl_t                  ctl,
  input  logic [e2c_pkg::DNUM_W-1:0]          dnum,
  output logic [e2c_pkg::YEAR_W-1:0]          year,
  output logic [e2c_pkg::MONTH_W-1:0]         month,
  output logic [e2c_pkg::DAY_W-1:0]           day
);

  localparam int DN_W = e2c_pkg::DNUM_W;

  localparam int ERA_S = DN_W + 18;
  localparam int ERA_RW = 25;
  localparam logic [ERA_RW-1:0] RCP_ERA =
      ERA_RW'(((64'd1 << ERA_S) + 64'd146096) / 64'd146097);

  localparam int C4_S = 18 + 11;
  localparam logic [18:0] RCP_1460 = 19'(((64'd1 << C4_S) + 64'd1459) / 64'd1460);
  localparam int YR_S = 18 + 9;
  localparam logic [18:0] RCP_365  = 19'(((64'd1 << YR_S) + 64'd364) / 64'd365);
  localparam int MP_S = 11 + 8;
  localparam logic [11:0] RCP_153  = 12'(((64'd1 << MP_S) + 64'd152) / 64'd153);

  localparam logic [17:0] CENT1 = 18'd36524;
  localparam logic [17:0] CENT2 = 18'd73048;
  localparam logic [17:0] CENT3 = 18'd109572;
  localparam logic [17:0] CENT4 = 18'd146096;
  localparam logic [3:0]  MP_JAN = 4'd10;
  localparam logic [15:0] YEAR_BIAS = 16'(e2c_pkg::ERA_BIAS * 400);

  logic [48:0]      era_prod;
  logic [6:0]       era_r;
  logic [DN_W-1:0]  dn4_r;
  logic [17:0]      doe_nxt, doe_r, doe6_r, doe7_r;
  logic [15:0]      e400_nxt, e400_r, e400_6_r, e400_7_r, e400_8_r, e400_9_r;
  logic [36:0]      c4_prod;
  logic [6:0]       c1460;
  logic [2:0]       c36524;
  logic             c146096;
  logic [17:0]      t_nxt, t_r;
  logic [36:0]      yr_prod;
  logic [8:0]       yoe_r, yoe8_r, yoe9_r;
  logic [1:0]       c100;
  logic [8:0]       doy_nxt, doy_r, doy9_r;
  logic [10:0]      mp_arg;
  logic [22:0]      mp_prod;
  logic [3:0]       mp_r;
  logic [e2c_pkg::YEAR_W-1:0]  year_nxt, year_r;
  logic [e2c_pkg::MONTH_W-1:0] month_nxt, month_r;
  logic [e2c_pkg::DAY_W-1:0]   day_nxt, day_r;

  assign era_prod = 49'(dnum) * 49'(RCP_ERA);

  assign doe_nxt  = 18'(dn4_r - DN_W'(era_r) * 24'd146097);
  assign e400_nxt = 16'(era_r) * 16'd400;

  // doe - doe/1460 + doe/36524 - doe/146096
  assign c4_prod = 37'(doe_r) * 37'(RCP_1460);
  assign c1460   = c4_prod[35:29];
  assign c36524  = 3'(doe_r >= CENT1) + 3'(doe_r >= CENT2) + 3'(doe_r >= CENT3)
                 + 3'(doe_r >= CENT4);
  assign c146096 = (doe_r >= CENT4);
  assign t_nxt   = doe_r - 18'(c1460) + 18'(c36524) - 18'(c146096);

  assign yr_prod = 37'(t_r) * 37'(RCP_365);

  assign c100    = 2'(yoe_r >= 9'd100) + 2'(yoe_r >= 9'd200) + 2'(yoe_r >= 9'd300);
  assign doy_nxt = 9'(doe7_r - (18'(yoe_r) * 18'd365 + 18'(yoe_r >> 2) - 18'(c100)));

  assign mp_arg  = {doy_r, 2'b00} + 11'(doy_r) + 11'd2;
  assign mp_prod = 23'(mp_arg) * 23'(RCP_153);

  // January and February close the March-based year
  always_comb begin
    day_nxt = e2c_pkg::DAY_W'(doy9_r - e2c_pkg::month_start(mp_r) + 9'd1);
    if (mp_r >= MP_JAN) begin
      month_nxt = mp_r - 4'd9;
      year_nxt  = e400_9_r + 16'(yoe9_r) - YEAR_BIAS + 16'd1;
    end else begin
      month_nxt = mp_r + 4'd3;
      year_nxt  = e400_9_r + 16'(yoe9_r) - YEAR_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      era_r <= era_prod[ERA_S+6:ERA_S];
      dn4_r <= dnum;
    end
    if (ctl.en[5]) begin
      doe_r  <= doe_nxt;
      e400_r <= e400_nxt;
    end
    if (ctl.en[6]) begin
      t_r      <= t_nxt;
      doe6_r   <= doe_r;
      e400_6_r <= e400_r;
    end
    if (ctl.en[7]) begin
      yoe_r    <= yr_prod[35:27];
      doe7_r   <= doe6_r;
      e400_7_r <= e400_6_r;
    end
    if (ctl.en[8]) begin
      doy_r    <= doy_nxt;
      yoe8_r   <= yoe_r;
      e400_8_r <= e400_7_r;
    end
    if (ctl.en[9]) begin
      mp_r     <= mp_prod[22:19];
      doy9_r   <= doy_r;
      yoe9_r   <= yoe8_r;
      e400_9_r <= e400_8_r;
    end
    if (ctl.en[10]) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;

endmodule

>>> rtl/e2c_time_of_day.sv
`timescale 1ns / 1ps

module e2c_time_of_day (
  input  logic                                clk,
  input  e2c_pkg::pipe_ctl_t                  ctl,
  input  logic [e2c_pkg::DNUM_W-1:0]          dnum,
  input  logic [e2c_pkg::SOD_W-1:0]           sod,
  input  logic [e2c_pkg::BIAS_W-1:0]          bias,
  output logic [e2c_pkg::HOUR_W-1:0]          hour,
  output logic [e2c_pkg::MIN_W-1:0]           minute,
  output logic [e2c_pkg::NEXT_W-1:0]          next_midnight
);

  localparam int SW = e2c_pkg::SOD_W;
  localparam int HW = e2c_pkg::HOUR_W;
  localparam int MW = e2c_pkg::MIN_W;
  localparam int NW = e2c_pkg::NEXT_W;
  localparam int PW = e2c_pkg::BIAS_W + 2;

  localparam int HR_S = SW + 12;
  localparam logic [17:0] RCP_3600 = 18'(((64'd1 << HR_S) + 64'd3599) / 64'd3600);
  localparam int MN_S = 12 + 6;
  localparam logic [12:0] RCP_60   = 13'(((64'd1 << MN_S) + 64'd59) / 64'd60);

  logic [34:0]     hr_prod;
  logic [HW-1:0]   hour4_r, hour5_r;
  logic [SW-1:0]   sod4_r;
  logic [PW-1:0]   nmp_nxt, nmp_r;
  logic [11:0]     remh_nxt, remh_r;
  logic [NW-1:0]   nm_nxt, nm5_r;
  logic [24:0]     mn_prod;
  logic [HW-1:0]   hour_d_r [6:10];
  logic [MW-1:0]   min_d_r  [6:10];
  logic [NW-1:0]   nm_d_r   [6:10];

  assign hr_prod = 35'(sod) * 35'(RCP_3600);
  // midnight after the biased day, still in biased seconds
  assign nmp_nxt = (PW'(dnum) + PW'(1)) * PW'(86400);

  assign remh_nxt = 12'(sod4_r - SW'(hour4_r) * 17'd3600);
  assign nm_nxt   = NW'(nmp_r - PW'(bias));

  assign mn_prod = 25'(remh_r) * 25'(RCP_60);

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      hour4_r <= hr_prod[HR_S+HW-1:HR_S];
      sod4_r  <= sod;
      nmp_r   <= nmp_nxt;
    end
    if (ctl.en[5]) begin
      remh_r  <= remh_nxt;
      hour5_r <= hour4_r;
      nm5_r   <= nm_nxt;
    end
    if (ctl.en[6]) begin
      hour_d_r[6] <= hour5_r;
      min_d_r[6]  <= mn_prod[MN_S+MW-1:MN_S];
      nm_d_r[6]   <= nm5_r;
    end
    for (int k = 7; k <= 10; k++) begin
      if (ctl.en[k]) begin
        hour_d_r[k] <= hour_d_r[k-1];
        min_d_r[k]  <= min_d_r[k-1];
        nm_d_r[k]   <= nm_d_r[k-1];
      end
    end
  end

  assign hour          = hour_d_r[10];
  assign minute        = min_d_r[10];
  assign next_midnight = nm_d_r[10];

endmodule

>>> rtl/epoch_to_civil_datetime.sv
`timescale 1ns / 1ps

// Converts UTC epoch seconds to local civil date and time.
// in_chan carries one signed 40-bit epoch per request; out_chan returns the
// local year, month, day, hour, minute and the UTC epoch of the next local
// midnight. Both channels move a request on a clock edge where valid and
// ready are both high.
// cfg_we / cfg_wdata write the signed zone offset in seconds; write it only
// while no request is in flight.
// A request passes through eleven register stages, the first of which captures
// it at the accepting edge; out_chan.valid is the valid bit of the last stage.
// One request is taken per cycle while the output is drained.
// Reset clears every stage valid bit and sets the offset to +28800 s.
// When the receiver holds ready low the result stays put; stages behind it
// keep advancing into empty slots, and in_chan.ready drops only once every
// stage is occupied.

module epoch_to_civil_datetime (
  input  logic                               clk,
  input  logic                               rst_n,
  e2c_in_if.sink                             in_chan,
  e2c_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic signed [e2c_pkg::OFS_W-1:0]   cfg_wdata
);

  localparam int BW = e2c_pkg::BIAS_W;

  e2c_pkg::pipe_ctl_t          ctl;
  logic [BW-1:0]               bias_r, bias_nxt;
  logic [e2c_pkg::DNUM_W-1:0]  dnum;
  logic [e2c_pkg::SOD_W-1:0]   sod;
  logic [e2c_pkg::YEAR_W-1:0]  year;
  logic [e2c_pkg::MONTH_W-1:0] month;
  logic [e2c_pkg::DAY_W-1:0]   day;
  logic [e2c_pkg::HOUR_W-1:0]  hour;
  logic [e2c_pkg::MIN_W-1:0]   minute;
  logic [e2c_pkg::NEXT_W-1:0]  next_midnight;

  // offset is held pre-added to the day bias
  assign bias_nxt = BW'(e2c_pkg::SEC_BIAS)
                  + {{(BW - e2c_pkg::OFS_W){cfg_wdata[e2c_pkg::OFS_W-1]}}, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= e2c_pkg::BIAS_RESET;
    end else if (cfg_we) begin
      bias_r <= bias_nxt;
    end
  end

  e2c_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  e2c_day_split u_split (
    .clk   (clk),
    .ctl   (ctl),
    .epoch (in_chan.epoch_seconds),
    .bias  (bias_r),
    .dnum  (dnum),
    .sod   (sod)
  );

  e2c_civil_date u_date (
    .clk   (clk),
    .ctl   (ctl),
    .dnum  (dnum),
    .year  (year),
    .month (month),
    .day   (day)
  );

  e2c_time_of_day u_tod (
    .clk           (clk),
    .ctl           (ctl),
    .dnum          (dnum),
    .sod           (sod),
    .bias          (bias_r),
    .hour          (hour),
    .minute        (minute),
    .next_midnight (next_midnight)
  );

  assign out_chan.civil_year          = year;
  assign out_chan.civil_month         = month;
  assign out_chan.civil_day           = day;
  assign out_chan.local_hour          = hour;
  assign out_chan.local_minute        = minute;
  assign out_chan.next_midnight_epoch = next_midnight;

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_chan.valid |-> (out_chan.civil_month >= 4'd1 && out_chan.civil_month <= 4'd12
                          && out_chan.civil_day >= 5'd1))
    else $error("civil date out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_chan.valid |-> (out_chan.local_hour <= 5'd23 && out_chan.local_minute <= 6'd59))
    else $error("local time out of range");

endmodule

>>> tb/sv/epoch_to_civil_datetime_tb.sv
`timescale 1ns / 1ps

module epoch_to_civil_datetime_tb;

  localparam int     EPOCH_W     = e2c_pkg::EPOCH_W;
  localparam int     OFS_W       = e2c_pkg::OFS_W;
  localparam int     YEAR_W      = e2c_pkg::YEAR_W;
  localparam int     MONTH_W     = e2c_pkg::MONTH_W;
  localparam int     DAY_W       = e2c_pkg::DAY_W;
  localparam int     HOUR_W      = e2c_pkg::HOUR_W;
  localparam int     MIN_W       = e2c_pkg::MIN_W;
  localparam int     NEXT_W      = e2c_pkg::NEXT_W;
  localparam int     NSTG        = e2c_pkg::NSTG;
  localparam longint OFS_RESET   = e2c_pkg::OFS_RESET;

  localparam int     CYCLE_LIMIT = 600000;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 100;
  localparam longint EPOCH_MAX   = 64'sd549755813887;
  localparam longint EPOCH_MIN   = -64'sd549755813888;
  localparam longint SECS_DAY    = 86400;

  typedef struct packed {
    logic signed [YEAR_W-1:0]  year;
    logic        [MONTH_W-1:0] month;
    logic        [DAY_W-1:0]   day;
    logic        [HOUR_W-1:0]  hour;
    logic        [MIN_W-1:0]   minute;
    logic signed [NEXT_W-1:0]  next_midnight;
  } civil_t;

  typedef struct packed {
    logic signed [OFS_W-1:0]   ofs;
    logic signed [EPOCH_W-1:0] epoch;
    logic                      known;
    civil_t                    want;
  } date_row_t;

  localparam civil_t NO_DATE = '0;

  localparam int N_DIRECTED = 21;
  localparam date_row_t DIRECTED [N_DIRECTED] = '{
    // reset offset (UTC+8)
    '{17'sd28800, 40'sd0, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd8, 6'd0, 41'sd57600}},
    '{17'sd28800, -40'sd28800, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 41'sd57600}},
    '{17'sd28800, -40'sd28801, 1'b1, '{16'sd1969, 4'd12, 5'd31, 5'd23, 6'd59, -41'sd28800}},
    '{17'sd28800, 40'sh7F_FFFF_FFFF, 1'b0, NO_DATE},
    '{17'sd28800, 40'sh80_0000_0000, 1'b0, NO_DATE},
    // UTC
    '{17'sd0, 40'sd0, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 41'sd86400}},
    '{17'sd0, -40'sd1, 1'b1, '{16'sd1969, 4'd12, 5'd31, 5'd23, 6'd59, 41'sd0}},
    '{17'sd0, 40'sd86399, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd23, 6'd59, 41'sd86400}},
    '{17'sd0, 40'sd951782400, 1'b1,
      '{16'sd2000, 4'd2, 5'd29, 5'd0, 6'd0, 41'sd951868800}},
    '{17'sd0, 40'sd951868800, 1'b1,
      '{16'sd2000, 4'd3, 5'd1, 5'd0, 6'd0, 41'sd951955200}},
    '{17'sd0, 40'sd4107542399, 1'b0, NO_DATE},
    '{17'sd0, -40'sd62135596800, 1'b1,
      '{16'sd1, 4'd1, 5'd1, 5'd0, 6'd0, -41'sd62135510400}},
    '{17'sd0, -40'sd62167219200, 1'b1,
      '{16'sd0, 4'd1, 5'd1, 5'd0, 6'd0, -41'sd62167132800}},
    '{17'sd0, -40'sd62167219201, 1'b1,
      '{-16'sd1, 4'd12, 5'd31, 5'd23, 6'd59, -41'sd62167219200}},
    // offsets of +/-50400 s and at the limits of the register
    '{17'sd50400, 40'sd0, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd14, 6'd0, 41'sd36000}},
    '{-17'sd50400, 40'sd0, 1'b1, '{16'sd1969, 4'd12, 5'd31, 5'd10, 6'd0, 41'sd50400}},
    '{17'sd65535, 40'sd0, 1'b1, '{16'sd1970, 4'd1, 5'd1, 5'd18, 6'd12, 41'sd20865}},
    '{17'sd65535, 40'sh7F_FFFF_FFFF, 1'b0, NO_DATE},
    '{17'sh10000, 40'sd0, 1'b1, '{16'sd1969, 4'd12, 5'd31, 5'd5, 6'd47, 41'sd65536}},
    '{17'sh10000, 40'sh80_0000_0000, 1'b0, NO_DATE},
    '{17'sd19800, 40'sd1234567890, 1'b0, NO_DATE}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic signed [OFS_W-1:0] cfg_wdata;

  e2c_in_if  in_bus ();
  e2c_out_if out_bus ();

  civil_t                  pending_dates [$];
  logic signed [OFS_W-1:0] zone_ofs = OFS_W'(OFS_RESET);
  int                      mismatches = 0;
  int                      cycles = 0;

  epoch_to_civil_datetime dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // local date, time of day and next local midnight for one request
  function automatic civil_t civil_from_epoch(input logic signed [EPOCH_W-1:0] epoch,
                                              input logic signed [OFS_W-1:0] ofs);
    longint loc, dnum, sod, z, era, doe, yoe, doy, mp, dd, mm, yr, nxt;
    civil_t r;
    loc  = longint'(epoch) + longint'(ofs);
    dnum = floor_div(loc, SECS_DAY);
    sod  = loc - dnum * SECS_DAY;
    // eras of 400 years, each year starting on 1 March
    z    = dnum + 719468;
    era  = floor_div(z, 146097);
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mm   = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
    nxt  = (dnum + 1) * SECS_DAY - longint'(ofs);
    r.year          = YEAR_W'(yr);
    r.month         = MONTH_W'(mm);
    r.day           = DAY_W'(dd);
    r.hour          = HOUR_W'(sod / 3600);
    r.minute        = MIN_W'((sod % 3600) / 60);
    r.next_midnight = NEXT_W'(nxt);
    return r;
  endfunction

  function automatic logic signed [EPOCH_W-1:0] pick_epoch(input logic signed [OFS_W-1:0] ofs);
    longint k, s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = {$urandom, $urandom};
      3, 4:    s = longint'($signed($urandom)) * 4;
      5, 6: begin
        // within a few seconds of a local midnight
        k = longint'($signed($urandom)) % 64'sd6300000;
        s = k * SECS_DAY - longint'(ofs) + longint'($urandom_range(0, 6)) - 3;
      end
      7, 8: begin
        // around 1 March of a century year, 400-year boundaries included
        k = longint'($urandom_range(0, 76)) - 35;
        k = k * 146097 + longint'($urandom_range(0, 3)) * 36524 - 719468
            + longint'($urandom_range(0, 2)) - 1;
        s = k * SECS_DAY - longint'(ofs) + longint'($urandom_range(0, 4)) - 2;
      end
      default: begin
        if ($urandom_range(0, 1)) s = EPOCH_MAX - longint'($urandom_range(0, 100000));
        else s = EPOCH_MIN + longint'($urandom_range(0, 100000));
      end
    endcase
    return EPOCH_W'(s);
  endfunction

  task automatic send_epoch(input logic signed [EPOCH_W-1:0] e, input logic known,
                            input civil_t typed, input bit gappy);
    int gap, r;
    in_bus.valid         <= 1'b1;
    in_bus.epoch_seconds <= e;
    do @(posedge clk); while (!in_bus.ready);
    pending_dates.push_back(known ? typed : civil_from_epoch(e, zone_ofs));
    r = $urandom_range(0, 99);
    if (!gappy || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    in_bus.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic set_zone(input logic signed [OFS_W-1:0] v);
    drain_all();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    zone_ofs = v;
  endtask

  // result side: bursts of ready, then stalls of mostly short length
  initial begin
    int burst, hold, r;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 30) hold = 0;
      else if (r < 80) hold = $urandom_range(1, 3);
      else if (r < 95) hold = $urandom_range(4, 10);
      else hold = $urandom_range(20, 60);
      repeat (hold) begin
        out_bus.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    civil_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.civil_year, out_bus.civil_month, out_bus.civil_day,
              out_bus.local_hour, out_bus.local_minute, out_bus.next_midnight_epoch};
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: %0d-%0d-%0d %0d:%0d next %0d",
                   $realtime, got.year, got.month, got.day, got.hour, got.minute,
                   got.next_midnight);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: want %0d-%0d-%0d %0d:%0d next %0d,",
                      " got %0d-%0d-%0d %0d:%0d next %0d"}, $realtime,
                     want.year, want.month, want.day, want.hour, want.minute,
                     want.next_midnight, got.year, got.month, got.day, got.hour,
                     got.minute, got.next_midnight);
        end
      end
    end
  end

  initial begin
    logic signed [OFS_W-1:0] ofs;
    bit gappy;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_bus.valid         <= 1'b0;
    in_bus.epoch_seconds <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].ofs !== zone_ofs) set_zone(DIRECTED[i].ofs);
      send_epoch(DIRECTED[i].epoch, DIRECTED[i].known, DIRECTED[i].want, 1'b1);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       ofs = -17'sd50400;
        1:       ofs = 17'sd50400;
        2:       ofs = '0;
        3:       ofs = 17'sh10000;
        4:       ofs = 17'sd65535;
        default: ofs = OFS_W'($urandom);
      endcase
      gappy = (ph != 2);
      set_zone(ofs);
      repeat (PHASE_ITEMS) begin
        // now and then hold off until the pipeline has emptied
        if ($urandom_range(0, 99) == 0) drain_all();
        send_epoch(pick_epoch(zone_ofs), 1'b0, NO_DATE, gappy);
      end
    end

    drain_all();
    repeat (NSTG + 4) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
rtl/e2c_pkg.sv
rtl/e2c_in_if.sv
rtl/e2c_out_if.sv
rtl/e2c_pipe_ctrl.sv
rtl/e2c_day_split.sv
rtl/e2c_civil_date.sv
rtl/e2c_time_of_day.sv
rtl/epoch_to_civil_datetime.sv
tb/sv/epoch_to_civil_datetime_tb.sv
